FILE: src/pgr_pkg.sv
`timescale 1ns / 1ps
package pgr_pkg;

	// payload field widths
	localparam int VPAGE_W = 12;
	localparam int OFFS_W  = 14;
	localparam int TYPE_W  = 3;
	localparam int EVICT_W = 13;
	localparam int ADDR_W  = 20;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 17;
	localparam int FCNT_W = 5;
	localparam int PSIZE_W = 17;

	localparam logic [CFG_AW-1:0] REG_POLICY      = 2'd0;
	localparam logic [CFG_AW-1:0] REG_FRAME_COUNT = 2'd1;
	localparam logic [CFG_AW-1:0] REG_PAGE_SIZE   = 2'd2;

	localparam logic               POLICY_RST      = 1'b0;
	localparam logic [FCNT_W-1:0]  FRAME_COUNT_RST = 5'd16;
	localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 17'd4096;

	localparam logic POLICY_FIFO = 1'b1;

	// event codes
	localparam logic [TYPE_W-1:0] FT_READ_MISS   = 3'd0;
	localparam logic [TYPE_W-1:0] FT_WRITE_MISS  = 3'd1;
	localparam logic [TYPE_W-1:0] FT_FIRST_WRITE = 3'd2;
	localparam logic [TYPE_W-1:0] FT_READ_TRACK  = 3'd3;
	localparam logic [TYPE_W-1:0] FT_WRITE_TRACK = 3'd4;

	// frame chance marks
	localparam logic [1:0] CH_NONE  = 2'd0;
	localparam logic [1:0] CH_ONE   = 2'd1;
	localparam logic [1:0] CH_AGED  = 2'd2;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int VPAGE_BITS_DEF = 12;

	typedef struct packed {
		logic load;     // latch the fault beat
		logic start;    // fix up hand, arm lookup and sweep counters
		logic rd_idx;   // read page store at lookup index
		logic lk_step;  // advance lookup index
		logic sw_step;  // one sweep step at the hand
		logic rd_hand;  // read page store at the hand (victim)
		logic replace;  // load victim frame and report
		logic hit;      // update marks of hit frame and report if due
	} cmd_t;

	typedef struct packed {
		logic fifo;
		logic wr;
		logic lk_match;
		logic lk_last;
		logic sw_stop;
		logic hit_emit;
		logic out_free;
	} status_t;

endpackage

FILE: src/pgr_ifs.sv
`timescale 1ns / 1ps
interface pgr_fault_if;
	logic                          valid;
	logic                          ready;
	logic [pgr_pkg::VPAGE_W-1:0]   vpn;
	logic [pgr_pkg::OFFS_W-1:0]    word_offset;
	logic                          is_write;

	modport source (output valid, input ready, output vpn, output word_offset,
		output is_write);
	modport sink (input valid, output ready, input vpn, input word_offset,
		input is_write);
endinterface

interface pgr_report_if;
	logic                                 valid;
	logic                                 ready;
	logic [pgr_pkg::VPAGE_W-1:0]          fault_page;
	logic [pgr_pkg::TYPE_W-1:0]           event_kind;
	logic signed [pgr_pkg::EVICT_W-1:0]   victim_vpn;
	logic                                 needs_wb;
	logic [pgr_pkg::ADDR_W-1:0]           phys_addr;

	modport source (output valid, input ready, output fault_page, output event_kind,
		output victim_vpn, output needs_wb, output phys_addr);
	modport sink (input valid, output ready, input fault_page, input event_kind,
		input victim_vpn, input needs_wb, input phys_addr);
endinterface

FILE: src/pgr_ctrl.sv
`timescale 1ns / 1ps
module pgr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pgr_pkg::status_t st,
	output pgr_pkg::cmd_t    cmd
);
	import pgr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_LK_RD  = 3'd2;
	localparam logic [2:0] S_LK_CHK = 3'd3;
	localparam logic [2:0] S_SWEEP  = 3'd4;
	localparam logic [2:0] S_VIC_RD = 3'd5;
	localparam logic [2:0] S_REPL   = 3'd6;
	localparam logic [2:0] S_HIT    = 3'd7;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				// FIFO read faults skip the lookup entirely
				if (st.fifo && !st.wr) begin
					state_d = S_VIC_RD;
				end else begin
					state_d = S_LK_RD;
				end
			end
			S_LK_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_LK_CHK;
			end
			S_LK_CHK: begin
				if (st.lk_match) begin
					state_d = S_HIT;
				end else begin
					cmd.lk_step = 1'b1;
					if (st.lk_last) begin
						state_d = st.fifo ? S_VIC_RD : S_SWEEP;
					end else begin
						state_d = S_LK_RD;
					end
				end
			end
			S_SWEEP: begin
				if (st.sw_stop) begin
					state_d = S_VIC_RD;
				end else begin
					cmd.sw_step = 1'b1;
				end
			end
			S_VIC_RD: begin
				cmd.rd_hand = 1'b1;
				state_d     = S_REPL;
			end
			S_REPL: begin
				if (st.out_free) begin
					cmd.replace = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_HIT: begin
				if (!st.hit_emit || st.out_free) begin
					cmd.hit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/pgr_dp.sv
`timescale 1ns / 1ps
module pgr_dp #(
	parameter int MAX_FRAMES = pgr_pkg::MAX_FRAMES_DEF,
	parameter int VPAGE_BITS = pgr_pkg::VPAGE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pgr_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [pgr_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic [pgr_pkg::VPAGE_W-1:0]  vpn,
	input  logic [pgr_pkg::OFFS_W-1:0]   word_offset,
	input  logic                         is_write,
	input  pgr_pkg::cmd_t                cmd,
	output pgr_pkg::status_t             st,
	pgr_report_if.source                 report
);
	import pgr_pkg::*;

	localparam int PW       = (VPAGE_BITS < VPAGE_W) ? VPAGE_BITS : VPAGE_W;
	localparam int HW       = $clog2(MAX_FRAMES);
	localparam int NW       = $clog2(MAX_FRAMES + 1);
	localparam int RING_MAX = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;
	localparam int SW       = $clog2(3 * RING_MAX + 2);
	localparam int MW       = HW + ADDR_W;

	// configuration
	logic               policy_q;
	logic [FCNT_W-1:0]  frame_count_q;
	logic [PSIZE_W-1:0] page_size_q;

	// latched fault
	logic [PW-1:0]     page_q;
	logic [OFFS_W-1:0] offset_q;
	logic              wr_q;

	// ring state
	logic [HW-1:0] hand_q;
	logic [HW-1:0] idx_q;
	logic [NW-1:0] k_q;
	logic [SW-1:0] steps_q;
	logic          valid_q  [MAX_FRAMES];
	logic          ref_q    [MAX_FRAMES];
	logic          dirty_q  [MAX_FRAMES];
	logic [1:0]    chance_q [MAX_FRAMES];
	logic [PW-1:0] vpage_mem [MAX_FRAMES];
	logic [PW-1:0] rdata_q;

	// result register
	logic                      out_valid_q;
	logic [VPAGE_W-1:0]        out_page_q;
	logic [TYPE_W-1:0]         out_type_q;
	logic signed [EVICT_W-1:0] out_ev_q;
	logic                      out_wb_q;
	logic [ADDR_W-1:0]         out_addr_q;

	logic [8:0]        n9;
	logic [NW-1:0]     n;
	logic [SW-1:0]     limit;
	logic [HW-1:0]     hand_fix;
	logic [HW-1:0]     frame;
	logic [MW-1:0]     addr_full;
	logic [TYPE_W-1:0] hit_type;
	logic [TYPE_W-1:0] miss_type;
	logic              emit;

	function automatic logic [HW-1:0] next_of(input logic [HW-1:0] i,
		input logic [NW-1:0] cnt);
		logic [NW-1:0] nx;
		nx = NW'(i) + NW'(1);
		return (nx >= cnt) ? '0 : HW'(nx);
	endfunction

	// ring size: 0 acts as 1, clamp to the frame store
	always_comb begin
		if (frame_count_q == '0) begin
			n9 = 9'd1;
		end else if (9'(frame_count_q) > 9'(MAX_FRAMES)) begin
			n9 = 9'(MAX_FRAMES);
		end else begin
			n9 = 9'(frame_count_q);
		end
	end
	assign n        = NW'(n9);
	assign limit    = SW'({n, 1'b0}) + SW'(n) + SW'(1);
	assign hand_fix = (NW'(hand_q) >= n) ? '0 : hand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POLICY_RST;
			frame_count_q <= FRAME_COUNT_RST;
			page_size_q   <= PAGE_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_POLICY:      policy_q      <= cfg_wdata[0];
				REG_FRAME_COUNT: frame_count_q <= cfg_wdata[FCNT_W-1:0];
				REG_PAGE_SIZE:   page_size_q   <= cfg_wdata[PSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q   <= vpn[PW-1:0];
			offset_q <= word_offset;
			wr_q     <= is_write;
		end
	end

	// page store: one read port, address by phase
	always_ff @(posedge clk) begin
		if (cmd.rd_idx) begin
			rdata_q <= vpage_mem[idx_q];
		end else if (cmd.rd_hand) begin
			rdata_q <= vpage_mem[hand_q];
		end
		if (cmd.replace) begin
			vpage_mem[hand_q] <= page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q  <= '0;
			idx_q   <= '0;
			k_q     <= '0;
			steps_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				valid_q[i]  <= 1'b0;
				ref_q[i]    <= 1'b0;
				dirty_q[i]  <= 1'b0;
				chance_q[i] <= CH_NONE;
			end
		end else begin
			if (cmd.start) begin
				hand_q  <= hand_fix;
				idx_q   <= hand_fix;
				k_q     <= '0;
				steps_q <= '0;
			end
			if (cmd.lk_step) begin
				idx_q <= next_of(idx_q, n);
				k_q   <= k_q + NW'(1);
			end
			if (cmd.sw_step) begin
				if (dirty_q[hand_q] && !ref_q[hand_q]) begin
					chance_q[hand_q] <= CH_AGED;
				end else begin
					ref_q[hand_q]    <= 1'b0;
					chance_q[hand_q] <= CH_ONE;
				end
				hand_q  <= next_of(hand_q, n);
				steps_q <= steps_q + SW'(1);
			end
			if (cmd.replace) begin
				valid_q[hand_q] <= 1'b1;
				dirty_q[hand_q] <= wr_q;
				if (policy_q != POLICY_FIFO) begin
					ref_q[hand_q]    <= 1'b1;
					chance_q[hand_q] <= CH_NONE;
				end
				hand_q <= next_of(hand_q, n);
			end
			if (cmd.hit) begin
				dirty_q[idx_q] <= dirty_q[idx_q] | wr_q;
				if (policy_q != POLICY_FIFO) begin
					ref_q[idx_q]    <= 1'b1;
					chance_q[idx_q] <= CH_NONE;
				end
			end
		end
	end

	always_comb begin
		if (policy_q == POLICY_FIFO || !dirty_q[idx_q]) begin
			hit_type = FT_FIRST_WRITE;
		end else begin
			hit_type = FT_WRITE_TRACK;
		end
		if (policy_q != POLICY_FIFO && !wr_q) begin
			hit_type = FT_READ_TRACK;
		end
	end
	assign miss_type = wr_q ? FT_WRITE_MISS : FT_READ_MISS;

	always_comb begin
		st          = '0;
		st.fifo     = (policy_q == POLICY_FIFO);
		st.wr       = wr_q;
		st.lk_match = valid_q[idx_q] && (rdata_q == page_q);
		st.lk_last  = (k_q == n - NW'(1));
		st.sw_stop  = !(ref_q[hand_q] || dirty_q[hand_q]) || (steps_q >= limit)
			|| (chance_q[hand_q] == CH_AGED);
		if (policy_q == POLICY_FIFO) begin
			st.hit_emit = !dirty_q[idx_q];
		end else begin
			st.hit_emit = !wr_q || !dirty_q[idx_q] || !ref_q[idx_q];
		end
		st.out_free = !out_valid_q || report.ready;
	end

	assign emit      = cmd.replace || (cmd.hit && st.hit_emit);
	assign frame     = cmd.replace ? hand_q : idx_q;
	assign addr_full = MW'(frame) * MW'(page_size_q) + MW'({offset_q, 2'b00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_page_q <= VPAGE_W'(page_q);
			out_addr_q <= addr_full[ADDR_W-1:0];
			if (cmd.replace) begin
				out_type_q <= miss_type;
				out_ev_q   <= valid_q[hand_q] ? $signed(EVICT_W'(rdata_q)) : -EVICT_W'(1);
				out_wb_q   <= dirty_q[hand_q];
			end else begin
				out_type_q <= hit_type;
				out_ev_q   <= -EVICT_W'(1);
				out_wb_q   <= 1'b0;
			end
		end
	end

	assign report.valid      = out_valid_q;
	assign report.fault_page = out_page_q;
	assign report.event_kind = out_type_q;
	assign report.victim_vpn = out_ev_q;
	assign report.needs_wb   = out_wb_q;
	assign report.phys_addr  = out_addr_q;

endmodule

FILE: src/page_replacement_fifo_third_chance.sv
`timescale 1ns / 1ps
// One fault at a time, n = ring size. FIFO read faults skip the lookup and replace at the hand;
// other faults probe the frames from the hand, and a hit updates the marks of the matching frame.
// A FIFO write miss replaces at the hand; a third-chance miss sweeps at most 3*n+1 steps first.
// A held result register stalls the fault in its last cycle; a new fault is taken the cycle after.
// Reset clears frame marks, the hand, counters and result valid; the page store is not cleared.
module page_replacement_fifo_third_chance #(
	parameter int MAX_FRAMES = pgr_pkg::MAX_FRAMES_DEF,
	parameter int VPAGE_BITS = pgr_pkg::VPAGE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pgr_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [pgr_pkg::CFG_DW-1:0]   cfg_wdata,
	pgr_fault_if.sink                    fault,
	pgr_report_if.source                 report
);
	import pgr_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    in_rdy;

	assign fault.ready = in_rdy;

	pgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fault.valid),
		.in_ready (in_rdy),
		.st       (st),
		.cmd      (cmd)
	);

	pgr_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.VPAGE_BITS (VPAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.vpn         (fault.vpn),
		.word_offset (fault.word_offset),
		.is_write    (fault.is_write),
		.cmd         (cmd),
		.st          (st),
		.report      (report)
	);

endmodule
